// ----- src/cdp_pkg.sv -----
// ----------------------------------------------------------------------------
// cdp_pkg: shared definitions for the chunk delta packet parser
// Result record layout, kind and status codes, and the push bundle that
// the parser hands to the result queue.
// ----------------------------------------------------------------------------
package cdp_pkg;

    localparam int HEADER_BYTES = 25;
    localparam int EDIT_BYTES   = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int TDATA_W      = 232;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_EDIT   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_WRONG_TYPE = 2'd1;
    localparam logic [1:0] ST_TRUNCATED  = 2'd2;
    localparam logic [1:0] ST_TRAILING   = 2'd3;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_EDITS  = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] chunk_x;
        logic signed [31:0] chunk_y;
        logic signed [31:0] chunk_z;
        logic [63:0]        resulting_version;
        logic [31:0]        edit_total;
        logic [7:0]         edit_x;
        logic [7:0]         edit_y;
        logic [7:0]         edit_z;
        logic [7:0]         block_id;
        logic [1:0]         status;
        logic               last_result;
    } result_t;

    // Up to two results per byte: slot 0 first, slot 1 second.
    typedef struct packed {
        result_t    res0;
        result_t    res1;
        logic [1:0] count;
    } push_t;

endpackage

// ----- src/cdp_parser.sv -----
// ----------------------------------------------------------------------------
// cdp_parser: packet state and result formation
// Holds the header and edit assembly state and turns each accepted byte
// into zero, one or two result records.
// ----------------------------------------------------------------------------
module cdp_parser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [7:0]     cfg_wr_data,
    input  logic           beat_valid,
    input  logic [7:0]     data_byte,
    input  logic           end_of_packet,
    output cdp_pkg::push_t push
);
    import cdp_pkg::*;

    logic [7:0]  type_code_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  hidx_reg, hidx_next;
    logic [31:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [63:0] ver_reg, ver_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] seen_reg, seen_next;
    logic [1:0]  ebi_reg, ebi_next;
    logic [23:0] eb_reg, eb_next;
    logic [1:0]  err_reg, err_next;

    result_t main_res, stat_res;
    logic    main_valid;
    logic [2:0] hsub;

    always_comb begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        ver_next   = ver_reg;
        cnt_next   = cnt_reg;
        seen_next  = seen_reg;
        ebi_next   = ebi_reg;
        eb_next    = eb_reg;
        err_next   = err_reg;
        main_valid = 1'b0;
        main_res   = '0;
        stat_res   = '0;
        hsub       = '0;

        case (phase_reg)
            PH_HEADER: begin
                if (hidx_reg == 5'd0) begin
                    if (data_byte != type_code_reg) begin
                        err_next   = ST_WRONG_TYPE;
                        phase_next = PH_SKIP;
                    end
                end else if (hidx_reg inside {[5'd1:5'd4]}) begin
                    hsub = 3'(hidx_reg - 5'd1);
                    cx_next[{hsub[1:0], 3'b000} +: 8] = data_byte;
                end else if (hidx_reg inside {[5'd5:5'd8]}) begin
                    hsub = 3'(hidx_reg - 5'd5);
                    cy_next[{hsub[1:0], 3'b000} +: 8] = data_byte;
                end else if (hidx_reg inside {[5'd9:5'd12]}) begin
                    hsub = 3'(hidx_reg - 5'd9);
                    cz_next[{hsub[1:0], 3'b000} +: 8] = data_byte;
                end else if (hidx_reg inside {[5'd13:5'd20]}) begin
                    hsub = 3'(hidx_reg - 5'd13);
                    ver_next[{hsub, 3'b000} +: 8] = data_byte;
                end else if (hidx_reg inside {[5'd21:5'd24]}) begin
                    hsub = 3'(hidx_reg - 5'd21);
                    cnt_next[{hsub[1:0], 3'b000} +: 8] = data_byte;
                end
                if (phase_next == PH_HEADER) begin
                    hidx_next = hidx_reg + 5'd1;
                    if (hidx_next >= 5'(HEADER_BYTES)) begin
                        main_valid                 = 1'b1;
                        main_res.kind              = KIND_HEADER;
                        main_res.chunk_x           = cx_next;
                        main_res.chunk_y           = cy_next;
                        main_res.chunk_z           = cz_next;
                        main_res.resulting_version = ver_next;
                        main_res.edit_total        = cnt_next;
                        phase_next                 = PH_EDITS;
                        seen_next                  = '0;
                        ebi_next                   = '0;
                        eb_next                    = '0;
                    end
                end
            end
            PH_EDITS: begin
                if (seen_reg == cnt_reg) begin
                    err_next   = ST_TRAILING;
                    phase_next = PH_SKIP;
                end else if (ebi_reg != 2'(EDIT_BYTES - 1)) begin
                    eb_next[{ebi_reg, 3'b000} +: 8] = data_byte;
                    ebi_next = ebi_reg + 2'd1;
                end else begin
                    main_valid        = 1'b1;
                    main_res.kind     = KIND_EDIT;
                    main_res.edit_x   = eb_reg[7:0];
                    main_res.edit_y   = eb_reg[15:8];
                    main_res.edit_z   = eb_reg[23:16];
                    main_res.block_id = data_byte;
                    seen_next         = seen_reg + 32'd1;
                    ebi_next          = '0;
                    eb_next           = '0;
                end
            end
            default: begin
                // Skipping to the end of the packet after an error.
            end
        endcase

        main_res.last_result = ~end_of_packet;
        stat_res.kind        = KIND_STATUS;
        stat_res.last_result = 1'b1;
        if (err_next != ST_OK) begin
            stat_res.status = err_next;
        end else if (phase_next == PH_EDITS && seen_next == cnt_next && ebi_next == 2'd0) begin
            stat_res.status = ST_OK;
        end else begin
            stat_res.status = ST_TRUNCATED;
        end

        push = '0;
        if (beat_valid) begin
            if (main_valid) begin
                push.res0  = main_res;
                push.res1  = stat_res;
                push.count = end_of_packet ? 2'd2 : 2'd1;
            end else if (end_of_packet) begin
                push.res0  = stat_res;
                push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_code_reg <= '0;
        end else if (cfg_wr_en) begin
            type_code_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hidx_reg  <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            ver_reg   <= '0;
            cnt_reg   <= '0;
            seen_reg  <= '0;
            ebi_reg   <= '0;
            eb_reg    <= '0;
            err_reg   <= ST_OK;
        end else if (beat_valid) begin
            if (end_of_packet) begin
                phase_reg <= PH_HEADER;
                hidx_reg  <= '0;
                cx_reg    <= '0;
                cy_reg    <= '0;
                cz_reg    <= '0;
                ver_reg   <= '0;
                cnt_reg   <= '0;
                seen_reg  <= '0;
                ebi_reg   <= '0;
                eb_reg    <= '0;
                err_reg   <= ST_OK;
            end else begin
                phase_reg <= phase_next;
                hidx_reg  <= hidx_next;
                cx_reg    <= cx_next;
                cy_reg    <= cy_next;
                cz_reg    <= cz_next;
                ver_reg   <= ver_next;
                cnt_reg   <= cnt_next;
                seen_reg  <= seen_next;
                ebi_reg   <= ebi_next;
                eb_reg    <= eb_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// ----- src/cdp_out_queue.sv -----
// ----------------------------------------------------------------------------
// cdp_out_queue: result register queue
// Four-entry queue that takes up to two results per cycle and hands out
// one per output beat.
// ----------------------------------------------------------------------------
module cdp_out_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  cdp_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output cdp_pkg::result_t out_res
);
    import cdp_pkg::*;

    result_t    entry_reg [QUEUE_DEPTH];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] fill_reg, fill_next;
    logic       pop;

    assign out_valid = (fill_reg != 3'd0);
    assign out_res   = entry_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // Room for the worst case of two results from one byte.
    assign room      = (fill_reg <= 3'd2);
    assign fill_next = fill_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_reg + 2'd1] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            wr_reg   <= wr_reg + push.count;
            rd_reg   <= rd_reg + {1'b0, pop};
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- src/chunk_delta_packet_parser.sv -----
// ----------------------------------------------------------------------------
// chunk_delta_packet_parser: chunk delta packet parser top level
// A result is registered in the result queue before it is offered on m_tvalid.
// Throughput: one input byte per cycle while s_tready is high; a byte causes
// at most two results, drained one per output beat from a four-entry result
// queue. s_tready drops only while the queue holds three or more results.
// Reset: aresetn clears the parser state, the type code and the queue.
// ----------------------------------------------------------------------------
module chunk_delta_packet_parser (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration: the delta packet type code.
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    // Input byte stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tlast,   // end_of_packet
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // From the lowest bit: chunk_x[31:0], chunk_y[63:32], chunk_z[95:64],
    // resulting_version[159:96], edit_total[191:160], edit_x[199:192],
    // edit_y[207:200], edit_z[215:208], block_id[223:216], status[225:224],
    // zero fill[231:226].
    output logic [cdp_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast    // last_result
);
    import cdp_pkg::*;

    push_t   push;
    result_t out_res;
    logic    room;
    logic    s_beat;

    // A byte is taken whenever the queue can hold everything it may cause.
    assign s_tready = room;
    assign s_beat   = s_tvalid && room;

    cdp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .beat_valid    (s_beat),
        .data_byte     (s_tdata),
        .end_of_packet (s_tlast),
        .push          (push)
    );

    cdp_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result record onto the output beat.
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_result;
    assign m_tdata = {6'b000000, out_res.status, out_res.block_id, out_res.edit_z,
                      out_res.edit_y, out_res.edit_x, out_res.edit_total,
                      out_res.resulting_version, out_res.chunk_z, out_res.chunk_y,
                      out_res.chunk_x};

endmodule

// ----- verif/chunk_delta_packet_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunk_delta_packet_parser_tb: regression bench for the chunk delta parser
// Streams whole packets (good ones, short ones, wrong type, missing edits,
// trailing bytes and noise) through the parser under several idle and stall
// patterns. A behavioral parser in the bench predicts every result, and each
// output beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module chunk_delta_packet_parser_tb;

    import cdp_pkg::*;

    // The slowest legal run stays far below this many cycles.
    localparam int CYCLE_LIMIT = 500000;
    // Cycles allowed for the pipeline to settle after the last result.
    localparam int SETTLE_CYCLES = 8;
    // Input beats in each randomized traffic phase.
    localparam int RANDOM_BEATS = 330;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [7:0]           cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    chunk_delta_packet_parser u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Results that the bench's parser has predicted but the block has not
    // yet delivered, oldest first.
    result_t     pending_results[$];
    // Bytes of the packet currently being built for transmission.
    logic [7:0]  pkt_bytes[$];

    int          mismatches;
    int          beats_sent;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    // While nonzero, the receiver refuses every beat and counts this down.
    int          hold_left;

    // Shadow of the parser: type code register and per-packet state.
    logic [7:0]  delta_code;
    logic [1:0]  ps_phase;
    int          ps_hidx;
    logic [31:0] ps_cx;
    logic [31:0] ps_cy;
    logic [31:0] ps_cz;
    logic [63:0] ps_ver;
    logic [31:0] ps_count;
    logic [31:0] ps_edits;
    logic [1:0]  ps_ebi;
    logic [23:0] ps_ebytes;
    logic [1:0]  ps_err;

    always #5 aclk = ~aclk;

    // A global watchdog. If the block hangs, the run still ends with a verdict.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("chunk_delta_packet_parser regression: fail");
            $finish;
        end
    end

    // Receiver. A pending long hold-off takes priority; otherwise the ready is
    // dropped at random according to the current stall percentage.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // The packet state returns to this after reset and after every packet end.
    function automatic void clear_parse_state();
        ps_phase  = PH_HEADER;
        ps_hidx   = 0;
        ps_cx     = '0;
        ps_cy     = '0;
        ps_cz     = '0;
        ps_ver    = '0;
        ps_count  = '0;
        ps_edits  = '0;
        ps_ebi    = '0;
        ps_ebytes = '0;
        ps_err    = ST_OK;
    endfunction

    // Advances the shadow parser by one accepted byte and queues the results
    // that the byte should produce, in order.
    function automatic void parse_byte(input logic [7:0] b, input logic eop);
        result_t    res[2];
        int         n;
        logic [1:0] st;
        n      = 0;
        res[0] = '0;
        res[1] = '0;
        if (ps_phase == PH_HEADER) begin
            // The first byte carries the packet type; the next 24 form the
            // little-endian header fields.
            if (ps_hidx == 0) begin
                if (b != delta_code) begin
                    ps_err   = ST_WRONG_TYPE;
                    ps_phase = PH_SKIP;
                end
            end else if (ps_hidx <= 4) begin
                ps_cx[(ps_hidx - 1) * 8 +: 8] = b;
            end else if (ps_hidx <= 8) begin
                ps_cy[(ps_hidx - 5) * 8 +: 8] = b;
            end else if (ps_hidx <= 12) begin
                ps_cz[(ps_hidx - 9) * 8 +: 8] = b;
            end else if (ps_hidx <= 20) begin
                ps_ver[(ps_hidx - 13) * 8 +: 8] = b;
            end else begin
                ps_count[(ps_hidx - 21) * 8 +: 8] = b;
            end
            if (ps_phase == PH_HEADER) begin
                ps_hidx++;
                if (ps_hidx >= HEADER_BYTES) begin
                    res[n].kind              = KIND_HEADER;
                    res[n].chunk_x           = ps_cx;
                    res[n].chunk_y           = ps_cy;
                    res[n].chunk_z           = ps_cz;
                    res[n].resulting_version = ps_ver;
                    res[n].edit_total        = ps_count;
                    n++;
                    ps_phase  = PH_EDITS;
                    ps_edits  = '0;
                    ps_ebi    = '0;
                    ps_ebytes = '0;
                end
            end
        end else if (ps_phase == PH_EDITS) begin
            if (ps_edits == ps_count) begin
                // Every announced edit is in, so any further byte is surplus.
                ps_err   = ST_TRAILING;
                ps_phase = PH_SKIP;
            end else if (ps_ebi < EDIT_BYTES - 1) begin
                ps_ebytes[ps_ebi * 8 +: 8] = b;
                ps_ebi++;
            end else begin
                res[n].kind     = KIND_EDIT;
                res[n].edit_x   = ps_ebytes[7:0];
                res[n].edit_y   = ps_ebytes[15:8];
                res[n].edit_z   = ps_ebytes[23:16];
                res[n].block_id = b;
                n++;
                ps_edits++;
                ps_ebi    = '0;
                ps_ebytes = '0;
            end
        end
        // Skipping (and the unused phase encoding) consumes the byte silently.
        if (eop) begin
            if (ps_err != ST_OK) begin
                st = ps_err;
            end else if (ps_phase == PH_EDITS && ps_edits == ps_count && ps_ebi == 0) begin
                st = ST_OK;
            end else begin
                st = ST_TRUNCATED;
            end
            res[n].kind   = KIND_STATUS;
            res[n].status = st;
            n++;
            clear_parse_state();
        end
        if (n > 0) begin
            res[n - 1].last_result = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            pending_results.insert(pending_results.size(), res[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void note_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
            end
        end
    endfunction

    // Every output beat is unpacked and compared with the oldest prediction.
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind              = m_tuser;
            got.chunk_x           = m_tdata[31:0];
            got.chunk_y           = m_tdata[63:32];
            got.chunk_z           = m_tdata[95:64];
            got.resulting_version = m_tdata[159:96];
            got.edit_total        = m_tdata[191:160];
            got.edit_x            = m_tdata[199:192];
            got.edit_y            = m_tdata[207:200];
            got.edit_z            = m_tdata[215:208];
            got.block_id          = m_tdata[223:216];
            got.status            = m_tdata[225:224];
            got.last_result       = m_tlast;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result beat with nothing expected, kind %0d",
                             $realtime, got.kind);
                end
            end else begin
                want = pending_results.pop_front();
                note_field("kind", 64'(want.kind), 64'(got.kind));
                note_field("chunk_x", 64'(want.chunk_x), 64'(got.chunk_x));
                note_field("chunk_y", 64'(want.chunk_y), 64'(got.chunk_y));
                note_field("chunk_z", 64'(want.chunk_z), 64'(got.chunk_z));
                note_field("resulting_version", want.resulting_version,
                           got.resulting_version);
                note_field("edit_total", 64'(want.edit_total), 64'(got.edit_total));
                note_field("edit_x", 64'(want.edit_x), 64'(got.edit_x));
                note_field("edit_y", 64'(want.edit_y), 64'(got.edit_y));
                note_field("edit_z", 64'(want.edit_z), 64'(got.edit_z));
                note_field("block_id", 64'(want.block_id), 64'(got.block_id));
                note_field("status", 64'(want.status), 64'(got.status));
                note_field("last_result", 64'(want.last_result), 64'(got.last_result));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sending
    // ------------------------------------------------------------------------

    // Offers one byte, with random idle cycles in front of it, and waits for
    // the beat to be taken. The valid is left high on return so that the next
    // byte can follow back to back; anyone who stops sending must lower it.
    task automatic send_beat(input logic [7:0] b, input logic eop);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eop;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        parse_byte(b, eop);
        beats_sent++;
    endtask

    // Stops the sender and waits until every predicted result has come out.
    // At least one edge passes so the valid is never lowered and raised again
    // within one time step.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Writes the type code while the block is quiet. Mid-packet bytes can be
    // in flight without a result, so the task also idles after the last one.
    task automatic set_type_code(input logic [7:0] code);
        wait_all_results();
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        @(posedge aclk);
        delta_code = code;
        cfg_wr_en <= 1'b0;
    endtask

    // Sends the packet under construction, end flag on its last byte. When
    // pause_at names a byte index, the sender stops in front of that byte
    // until the block has delivered everything so far.
    task automatic send_packet(input int pause_at);
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            if (i == pause_at) begin
                wait_all_results();
            end
            send_beat(pkt_bytes[i], i == pkt_bytes.size() - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Packet construction
    // ------------------------------------------------------------------------

    // Appends one byte to the end of the packet under construction.
    function automatic void append_byte(input logic [7:0] b);
        pkt_bytes.insert(pkt_bytes.size(), b);
    endfunction

    function automatic void put_le(input logic [63:0] v, input int nbytes);
        for (int k = 0; k < nbytes; k++) begin
            append_byte(v[k * 8 +: 8]);
        end
    endfunction

    function automatic void build_header(input logic [7:0] code, input logic [31:0] cx,
                                         input logic [31:0] cy, input logic [31:0] cz,
                                         input logic [63:0] ver, input logic [31:0] cnt);
        pkt_bytes.delete();
        append_byte(code);
        put_le(64'(cx), 4);
        put_le(64'(cy), 4);
        put_le(64'(cz), 4);
        put_le(ver, 8);
        put_le(64'(cnt), 4);
    endfunction

    function automatic void random_header(input logic [7:0] code, input logic [31:0] cnt);
        build_header(code, $urandom, $urandom, $urandom, {$urandom, $urandom}, cnt);
    endfunction

    function automatic void add_random_bytes(input int nbytes);
        for (int k = 0; k < nbytes; k++) begin
            append_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void cut_packet(input int nbytes);
        while (pkt_bytes.size() > nbytes) begin
            void'(pkt_bytes.pop_back());
        end
    endfunction

    // Picks one packet shape. Most packets are well formed so that the edit
    // path gets deep coverage; the rest break the format in every known way.
    function automatic void make_random_packet();
        int          pick;
        int          cnt;
        int          full;
        logic [31:0] big_cnt;
        logic [7:0]  first;
        pick = $urandom_range(0, 99);
        cnt  = $urandom_range(0, 6);
        if (pick < 55) begin
            random_header(delta_code, cnt);
            add_random_bytes(cnt * EDIT_BYTES);
        end else if (pick < 65) begin
            // Header cut short somewhere after the type byte.
            random_header(delta_code, cnt);
            cut_packet($urandom_range(1, HEADER_BYTES - 1));
        end else if (pick < 73) begin
            first = 8'($urandom_range(0, 255));
            if (first == delta_code) begin
                first = first ^ (8'h1 << $urandom_range(0, 7));
            end
            random_header(first, cnt);
            add_random_bytes(cnt * EDIT_BYTES);
            cut_packet($urandom_range(1, pkt_bytes.size()));
        end else if (pick < 85) begin
            // Fewer complete edits than announced, possibly ending mid-edit.
            // Now and then the count is huge, which reaches its upper bits.
            if ($urandom_range(0, 3) == 0) begin
                big_cnt = $urandom;
                if (big_cnt < 7) begin
                    big_cnt = 32'hFFFF_FFFF;
                end
            end else begin
                big_cnt = $urandom_range(1, 6);
            end
            full = $urandom_range(0, (big_cnt > 6) ? 5 : big_cnt - 1);
            random_header(delta_code, big_cnt);
            add_random_bytes(full * EDIT_BYTES + $urandom_range(0, EDIT_BYTES - 1));
        end else if (pick < 95) begin
            random_header(delta_code, cnt);
            add_random_bytes(cnt * EDIT_BYTES + $urandom_range(1, 4));
        end else begin
            // Short noise: whatever the first byte happens to be.
            pkt_bytes.delete();
            add_random_bytes($urandom_range(1, 6));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Runs on the type code left by reset. The first header carries the most
    // negative, most positive and minus-one coordinates and an all-ones
    // version; with no edits announced, its last byte yields header and
    // status together.
    task automatic test_reset_code_headers();
        build_header(8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_packet(-1);
        // All-zero header, then one all-zero and one all-ones edit.
        build_header(8'h00, '0, '0, '0, '0, 32'd2);
        put_le(64'h0000_0000, 4);
        put_le(64'hFFFF_FFFF, 4);
        send_packet(-1);
    endtask

    // Packets that end too early: on the type byte itself, one byte short of
    // a full header, inside an edit, and far short of an all-ones count.
    task automatic test_truncation();
        pkt_bytes.delete();
        append_byte(delta_code);
        send_packet(-1);
        random_header(delta_code, 32'd0);
        cut_packet(HEADER_BYTES - 1);
        send_packet(-1);
        random_header(delta_code, 32'd1);
        add_random_bytes(2);
        send_packet(-1);
        random_header(delta_code, 32'hFFFF_FFFF);
        add_random_bytes(EDIT_BYTES);
        send_packet(-1);
    endtask

    // Type mismatch with the code at its top value: a lone zero byte, a longer
    // packet whose remaining bytes must all be skipped, then a matching packet.
    task automatic test_wrong_type();
        set_type_code(8'hFF);
        pkt_bytes.delete();
        append_byte(8'h00);
        send_packet(-1);
        random_header(8'h7E, 32'd1);
        add_random_bytes(EDIT_BYTES);
        send_packet(-1);
        random_header(8'hFF, 32'd1);
        add_random_bytes(EDIT_BYTES);
        send_packet(-1);
    endtask

    // Surplus bytes: one right after a header that announces no edits, and
    // three after the only announced edit, the last being all ones.
    task automatic test_trailing_bytes();
        random_header(delta_code, 32'd0);
        add_random_bytes(1);
        send_packet(-1);
        random_header(delta_code, 32'd1);
        add_random_bytes(EDIT_BYTES + 2);
        append_byte(8'hFF);
        send_packet(-1);
    endtask

    // The receiver holds off for a long stretch while a long packet keeps
    // coming, so the result queue fills and the input stalls. Afterwards the
    // sender stops in the middle of a packet until everything has drained.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_type_code(8'h00);
        hold_left = 300;
        random_header(delta_code, 32'd40);
        add_random_bytes(40 * EDIT_BYTES);
        send_packet(-1);
        random_header(delta_code, 32'd6);
        add_random_bytes(6 * EDIT_BYTES);
        send_packet(HEADER_BYTES + 5);
    endtask

    // One phase of random packets under a given idle and stall pattern and a
    // fresh random type code.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int start;
        set_type_code(8'($urandom_range(0, 255)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            make_random_packet();
            send_packet(-1);
        end
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        mismatches     = 0;
        beats_sent     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        delta_code     = 8'h00;
        clear_parse_state();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_code_headers();
        test_truncation();
        test_wrong_type();
        test_trailing_bytes();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(72, 0);
        test_random_traffic(0, 72);
        test_random_traffic(18, 18);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("chunk_delta_packet_parser regression: pass");
        end else begin
            $display("chunk_delta_packet_parser regression: fail");
        end
        $finish;
    end

endmodule
